### hw/rtl/mvan_pkg.sv
// ----------------------------------------------------------------------------
// mvan_pkg
// Shared types, constants and the arctangent step table for the minimum
// view-angle novelty core.
// ----------------------------------------------------------------------------
package mvan_pkg;

  localparam int MAX_VIEWS_DEF = 64;
  localparam int CORDIC_STEPS  = 20;

  localparam logic [15:0] ANGLE_180  = 16'd46080;
  localparam logic [15:0] THR_RESET  = 16'd2560;
  localparam logic signed [31:0] ACC_90  = 32'sd5898240;
  localparam logic signed [31:0] ACC_180 = 32'sd11796480;

  localparam logic KIND_PRELOAD = 1'b0;
  localparam logic KIND_QUERY   = 1'b1;

  localparam logic REG_THRESHOLD = 1'b0;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } view_t;

  typedef struct packed {
    logic        done;
    logic [15:0] angle;
  } angle_rsp_t;

  // atan(2^-i) in degrees times 65536, rounded
  function automatic logic signed [31:0] atan_step(input logic [4:0] i);
    logic signed [31:0] s;
    case (i)
      5'd0:  s = 32'sd2949120;
      5'd1:  s = 32'sd1740967;
      5'd2:  s = 32'sd919879;
      5'd3:  s = 32'sd466945;
      5'd4:  s = 32'sd234379;
      5'd5:  s = 32'sd117304;
      5'd6:  s = 32'sd58666;
      5'd7:  s = 32'sd29335;
      5'd8:  s = 32'sd14668;
      5'd9:  s = 32'sd7334;
      5'd10: s = 32'sd3667;
      5'd11: s = 32'sd1833;
      5'd12: s = 32'sd917;
      5'd13: s = 32'sd458;
      5'd14: s = 32'sd229;
      5'd15: s = 32'sd115;
      5'd16: s = 32'sd57;
      5'd17: s = 32'sd29;
      5'd18: s = 32'sd14;
      5'd19: s = 32'sd7;
      default: s = 32'sd0;
    endcase
    return s;
  endfunction

endpackage

### hw/rtl/mvan_if.sv
// ----------------------------------------------------------------------------
// mvan_if
// Valid/ready channels for view items and result items.
// ----------------------------------------------------------------------------
interface mvan_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [15:0] view_x;
  logic signed [15:0] view_y;
  logic signed [15:0] view_z;
  logic               append_if_novel;

  modport source (output valid, kind, view_x, view_y, view_z, append_if_novel,
                  input ready);
  modport sink (input valid, kind, view_x, view_y, view_z, append_if_novel,
                output ready);
endinterface

interface mvan_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] min_angle;
  logic        angle_valid;
  logic        novel;
  logic        appended;
  logic        table_full;

  modport source (output valid, min_angle, angle_valid, novel, appended, table_full,
                  input ready);
  modport sink (input valid, min_angle, angle_valid, novel, appended, table_full,
                output ready);
endinterface

### hw/rtl/mvan_angle.sv
// ----------------------------------------------------------------------------
// mvan_angle
// Iterative angle unit: dot and norms on one multiplier, integer square
// root two bits a step, then vectoring CORDIC one step a cycle.
// ----------------------------------------------------------------------------
module mvan_angle (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  mvan_pkg::view_t    a,
  input  mvan_pkg::view_t    b,
  output mvan_pkg::angle_rsp_t rsp
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_NPROD, S_REM, S_SQRT, S_ROT, S_CORDIC, S_OUT
  } state_t;

  state_t             state;
  logic [4:0]         cnt;
  mvan_pkg::view_t    va;
  mvan_pkg::view_t    vb;
  logic signed [33:0] dot;
  logic [31:0]        na2;
  logic [31:0]        nb2;
  logic [63:0]        prod;
  logic [63:0]        v;
  logic [63:0]        r;
  logic [63:0]        bitv;
  logic signed [63:0] x;
  logic signed [63:0] y;
  logic signed [31:0] acc;
  logic [15:0]        angle;
  logic               done;

  logic signed [15:0] op1;
  logic signed [15:0] op2;
  logic signed [31:0] mprod;
  logic signed [33:0] dot_abs;
  logic [31:0]        adot;
  logic [63:0]        rem_v;
  logic [64:0]        trial;
  logic               ge;
  logic signed [63:0] dx;
  logic signed [63:0] dy;
  logic signed [31:0] step;
  logic signed [31:0] acc_c;
  logic signed [31:0] acc_r;

  always_comb begin
    case (cnt)
      5'd0: begin op1 = va.x; op2 = vb.x; end
      5'd1: begin op1 = va.y; op2 = vb.y; end
      5'd2: begin op1 = va.z; op2 = vb.z; end
      5'd3: begin op1 = va.x; op2 = va.x; end
      5'd4: begin op1 = va.y; op2 = va.y; end
      5'd5: begin op1 = va.z; op2 = va.z; end
      5'd6: begin op1 = vb.x; op2 = vb.x; end
      5'd7: begin op1 = vb.y; op2 = vb.y; end
      5'd8: begin op1 = vb.z; op2 = vb.z; end
      default: begin op1 = '0; op2 = '0; end
    endcase
  end

  assign mprod   = op1 * op2;
  assign dot_abs = dot[33] ? -dot : dot;
  assign adot    = dot_abs[31:0];
  assign rem_v   = prod - (64'(adot) * 64'(adot));
  assign trial   = {1'b0, r} + {1'b0, bitv};
  assign ge      = {1'b0, v} >= trial;
  assign dx      = x >>> cnt;
  assign dy      = y >>> cnt;
  assign step    = mvan_pkg::atan_step(cnt);
  assign acc_c   = acc[31] ? 32'sd0 : ((acc > mvan_pkg::ACC_180) ? mvan_pkg::ACC_180 : acc);
  assign acc_r   = (acc_c + 32'sd128) >>> 8;

  assign rsp.done  = done;
  assign rsp.angle = angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      // pulse done for one cycle after the output step
      done <= (state == S_OUT);
      case (state)
        S_IDLE: begin
          if (start) begin
            va    <= a;
            vb    <= b;
            dot   <= '0;
            na2   <= '0;
            nb2   <= '0;
            cnt   <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (cnt < 5'd3) begin
            dot <= dot + 34'(mprod);
          end else if (cnt < 5'd6) begin
            na2 <= na2 + mprod[31:0];
          end else begin
            nb2 <= nb2 + mprod[31:0];
          end
          if (cnt == 5'd8) begin
            cnt   <= '0;
            state <= S_NPROD;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_NPROD: begin
          prod  <= 64'(na2) * 64'(nb2);
          state <= S_REM;
        end
        S_REM: begin
          v     <= rem_v;
          r     <= '0;
          bitv  <= 64'(1) << 62;
          cnt   <= '0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (ge) begin
            v <= v - trial[63:0];
            r <= (r >> 1) + bitv;
          end else begin
            r <= r >> 1;
          end
          bitv <= bitv >> 2;
          if (cnt == 5'd31) begin
            cnt   <= '0;
            state <= S_ROT;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_ROT: begin
          // turn obtuse pairs by 90 degrees first
          if (dot[33]) begin
            x   <= $signed(r) <<< 24;
            y   <= 64'(dot_abs) <<< 24;
            acc <= mvan_pkg::ACC_90;
          end else begin
            x   <= 64'(dot) <<< 24;
            y   <= $signed(r) <<< 24;
            acc <= 32'sd0;
          end
          cnt   <= '0;
          state <= S_CORDIC;
        end
        S_CORDIC: begin
          if (!y[63]) begin
            x   <= x + dy;
            y   <= y - dx;
            acc <= acc + step;
          end else begin
            x   <= x - dy;
            y   <= y + dx;
            acc <= acc - step;
          end
          if (cnt == 5'(mvan_pkg::CORDIC_STEPS - 1)) begin
            state <= S_OUT;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_OUT: begin
          angle <= acc_r[15:0];
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/min_view_angle_novelty_core.sv
// ----------------------------------------------------------------------------
// min_view_angle_novelty_core
// Bounded table of 3-D view vectors with a minimum-angle novelty test.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake        carries
//  query     in    valid/ready      kind, view_x/y/z, append_if_novel
//  result    out   valid/ready      min_angle, angle_valid, novel, appended,
//                                   table_full
//  apb       in    psel/penable     angle_threshold at byte address 0
//
// A preload item is stored as it is accepted, if the table has room. A query
// walks the stored views through the view memory one at a time: a zero entry
// is skipped and a nonzero one goes through the angle unit (9 multiply steps,
// 32 root steps, 20 CORDIC steps).
// Synchronous reset empties the table (count to zero) and restores the
// threshold; the memory contents are not cleared.
// One item is in flight at a time; a finished result waits in the pending
// register until the output register frees, and the next item is taken then.
// ----------------------------------------------------------------------------
module min_view_angle_novelty_core #(
  parameter int MAX_VIEWS = mvan_pkg::MAX_VIEWS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  mvan_in_if.sink      query,
  mvan_out_if.source   result,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int CW = $clog2(MAX_VIEWS + 1);
  localparam int AW = (MAX_VIEWS > 1) ? $clog2(MAX_VIEWS) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_CHECK, S_RUN, S_FINISH, S_HOLD
  } state_t;

  state_t          state;
  logic [15:0]     threshold;
  logic [CW-1:0]   count;
  logic [CW-1:0]   idx;
  mvan_pkg::view_t cur;
  logic            want_app;
  logic [15:0]     best;
  logic            below;

  // pending result
  logic [15:0]     r_min;
  logic            r_valid;
  logic            r_novel;
  logic            r_app;
  logic            r_full;

  // output register
  logic            ovalid;
  logic [15:0]     o_min;
  logic            o_valid;
  logic            o_novel;
  logic            o_app;
  logic            o_full;

  mvan_pkg::view_t mem [MAX_VIEWS];
  mvan_pkg::view_t rdata;

  mvan_pkg::view_t      qv;
  mvan_pkg::angle_rsp_t arsp;
  logic                 accept;
  logic                 has_room;
  logic                 fin_novel;
  logic                 we;
  logic                 start;
  logic                 last;
  logic                 load_out;

  assign qv.x      = query.view_x;
  assign qv.y      = query.view_y;
  assign qv.z      = query.view_z;
  assign accept    = query.valid && query.ready;
  assign query.ready = (state == S_IDLE);
  assign has_room  = count < CW'(MAX_VIEWS);
  assign fin_novel = !below;
  assign last      = (idx + CW'(1)) == count;
  assign start     = (state == S_CHECK) && (rdata != '0);
  assign load_out  = (state == S_HOLD) && (!ovalid || result.ready);

  // store on preload accept, or on a novel query that asks for it, if there is room
  assign we = has_room &&
              ((accept && query.kind == mvan_pkg::KIND_PRELOAD) ||
               (state == S_FINISH && fin_novel && want_app));

  assign pready = 1'b1;
  assign prdata = (paddr[2] == mvan_pkg::REG_THRESHOLD) ? {16'd0, threshold} : 32'd0;

  assign result.valid       = ovalid;
  assign result.min_angle   = o_min;
  assign result.angle_valid = o_valid;
  assign result.novel       = o_novel;
  assign result.appended    = o_app;
  assign result.table_full  = o_full;

  mvan_angle u_angle (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .a     (cur),
    .b     (rdata),
    .rsp   (arsp)
  );

  // view memory: write the fill slot, read the walk slot
  always_ff @(posedge clk) begin
    if (we) begin
      mem[count[AW-1:0]] <= (state == S_FINISH) ? cur : qv;
    end
    rdata <= mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= mvan_pkg::THR_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == mvan_pkg::REG_THRESHOLD) begin
      threshold <= pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      idx    <= '0;
      ovalid <= 1'b0;
    end else begin
      // load a new result or drop the one just taken
      if (load_out) begin
        ovalid <= 1'b1;
      end else if (ovalid && result.ready) begin
        ovalid <= 1'b0;
      end
      if (we) begin
        count <= count + CW'(1);
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cur      <= qv;
            want_app <= query.append_if_novel;
            best     <= mvan_pkg::ANGLE_180;
            below    <= 1'b0;
            idx      <= '0;
            r_min    <= '0;
            r_valid  <= 1'b0;
            r_novel  <= 1'b0;
            r_app    <= (query.kind == mvan_pkg::KIND_PRELOAD) && has_room;
            r_full   <= (query.kind == mvan_pkg::KIND_PRELOAD) && !has_room;
            if (query.kind == mvan_pkg::KIND_PRELOAD) begin
              state <= S_HOLD;
            end else if (qv == '0) begin
              // zero view: no angle, never stored
              state <= S_HOLD;
            end else if (count == '0) begin
              state <= S_FINISH;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          if (rdata == '0) begin
            // skip zero stored view
            idx   <= idx + CW'(1);
            state <= last ? S_FINISH : S_READ;
          end else begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (arsp.done) begin
            if (arsp.angle < best) best <= arsp.angle;
            if (arsp.angle < threshold) below <= 1'b1;
            idx   <= idx + CW'(1);
            state <= last ? S_FINISH : S_READ;
          end
        end
        S_FINISH: begin
          r_valid <= (count != '0);
          r_min   <= (count != '0) ? best : 16'd0;
          r_novel <= fin_novel;
          r_app   <= fin_novel && want_app && has_room;
          r_full  <= fin_novel && want_app && !has_room;
          state   <= S_HOLD;
        end
        S_HOLD: begin
          if (load_out) begin
            o_min   <= r_min;
            o_valid <= r_valid;
            o_novel <= r_novel;
            o_app   <= r_app;
            o_full  <= r_full;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
